// File: rtl/assert_macros.svh
// Assertion helpers; the using module provides clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/pidsc_pkg.sv
package pidsc_pkg;

  localparam int CHANNELS   = 4;
  localparam int IDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_W       = 2;
  localparam int FRAC_W     = 16;
  localparam int GAIN_W     = 32;
  localparam int SPD_W      = 16;
  localparam int ERR_W      = SPD_W + 1;
  localparam int DIFF_W     = ERR_W + 2;
  localparam int LIM_W      = 15;
  localparam int CEIL_W     = SPD_W;
  localparam int DRIVE_W    = 16;
  localparam int ACC_W      = DRIVE_W + FRAC_W;
  localparam int PROD_W     = GAIN_W + DIFF_W;
  localparam int SUM_W      = PROD_W + 3;
  localparam int IN_DATA_W  = 2 * SPD_W;
  localparam int OUT_USER_W = CH_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [GAIN_W-1:0] KP_RST   = GAIN_W'(1035469);
  localparam logic signed [GAIN_W-1:0] KI_RST   = GAIN_W'(1245);
  localparam logic signed [GAIN_W-1:0] KD_RST   = '0;
  localparam logic [LIM_W-1:0]         ILIM_RST = LIM_W'(5000);
  localparam logic [LIM_W-1:0]         OLIM_RST = LIM_W'(20000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP,
    REG_KI,
    REG_KD,
    REG_ILIM,
    REG_OLIM,
    REG_MODE,
    REG_ECEIL,
    REG_EDB
  } cfg_reg_e;

  typedef enum logic {
    MODE_POSITIONAL  = 1'b0,
    MODE_INCREMENTAL = 1'b1
  } loop_mode_e;

  typedef struct packed {
    logic signed [ERR_W-1:0] e1;
    logic signed [ERR_W-1:0] e2;
    logic signed [ACC_W-1:0] integ;
    logic signed [ACC_W-1:0] incr;
  } chan_state_t;

  // Symmetric clamp to +/- lim in Q.FRAC_W; result always fits ACC_W.
  function automatic logic signed [ACC_W-1:0] clamp_sym(
    input logic signed [SUM_W-1:0] v,
    input logic [LIM_W-1:0]        lim
  );
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    logic signed [SUM_W-1:0] r;
    hi = $signed(SUM_W'({lim, {FRAC_W{1'b0}}}));
    lo = -hi;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[ACC_W-1:0];
  endfunction

endpackage

// File: rtl/pid_speed_controller_four_channel.sv
// Channel    Direction  Handshake                 Payload
// cfg        in         cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
// s_axis     in         tvalid/tready             tdata: meas, target; tuser: channel
// m_axis     out        tvalid/tready             tdata: drive; tuser: channel, skipped
//
// One request per cycle while neither an output stall nor a channel hazard holds input off; six register stages.
// Per-channel state sits in one memory; read at accept, written back at the end of stage 4.
// A request waits while a non-skipped request for its channel is still in stages 1-4.
// Reset clears the per-channel valid bits, so state reads as zero until first written.
// Output stall backs up the pipeline stage by stage; empty stages keep taking requests.
`include "assert_macros.svh"

module pid_speed_controller_four_channel import pidsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] measured_speed, [31:16] target_speed
  input  logic [CH_W-1:0]       s_axis_tuser,   // [1:0] channel
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [DRIVE_W-1:0]    m_axis_tdata,   // [15:0] drive_value
  output logic [OUT_USER_W-1:0] m_axis_tuser    // [1:0] channel_out, [2] skipped
);

  // configuration
  logic signed [GAIN_W-1:0] kp_q, ki_q, kd_q;
  logic [LIM_W-1:0]         ilim_q, olim_q;
  loop_mode_e               mode_q;
  logic [CEIL_W-1:0]        eceil_q, edb_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= KP_RST;
      ki_q    <= KI_RST;
      kd_q    <= KD_RST;
      ilim_q  <= ILIM_RST;
      olim_q  <= OLIM_RST;
      mode_q  <= MODE_POSITIONAL;
      eceil_q <= '0;
      edb_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_KP:    kp_q    <= cfg_data_i[GAIN_W-1:0];
        REG_KI:    ki_q    <= cfg_data_i[GAIN_W-1:0];
        REG_KD:    kd_q    <= cfg_data_i[GAIN_W-1:0];
        REG_ILIM:  ilim_q  <= cfg_data_i[LIM_W-1:0];
        REG_OLIM:  olim_q  <= cfg_data_i[LIM_W-1:0];
        REG_MODE:  mode_q  <= loop_mode_e'(cfg_data_i[0]);
        REG_ECEIL: eceil_q <= cfg_data_i[CEIL_W-1:0];
        REG_EDB:   edb_q   <= cfg_data_i[CEIL_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  logic hazard, s_acc;

  assign rdy6 = !v6_q || m_axis_tready;
  assign rdy5 = !v5_q || rdy6;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  // stage 0: error and skip decision
  logic [CH_W-1:0]          ch_in;
  logic signed [SPD_W-1:0]  meas_in, targ_in;
  logic signed [ERR_W-1:0]  err_d;
  logic [ERR_W-1:0]         mag_d;
  logic                     skip_d;
  logic [IDX_W-1:0]         rd_idx;

  assign ch_in   = s_axis_tuser;
  assign meas_in = s_axis_tdata[SPD_W-1:0];
  assign targ_in = s_axis_tdata[2*SPD_W-1:SPD_W];
  assign err_d   = ERR_W'(targ_in) - ERR_W'(meas_in);
  assign mag_d   = err_d[ERR_W-1] ? ERR_W'(-err_d) : ERR_W'(err_d);
  assign skip_d  = (int'(ch_in) >= CHANNELS)
                || ((eceil_q != '0) && (mag_d > {1'b0, eceil_q}))
                || ((edb_q != '0) && (mag_d < {1'b0, edb_q}));
  assign rd_idx  = IDX_W'(ch_in);

  // state memory and its valid bits
  chan_state_t              mem_q [CHANNELS];
  logic [CHANNELS-1:0]      vld_q;
  chan_state_t              rd_q;
  logic                     rd_vld_q;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_idx;
  chan_state_t              wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= wr_data;
    end
    if (rdy1) begin
      rd_q <= mem_q[rd_idx];
    end
  end

  // stage registers
  logic [CH_W-1:0]           s1_ch_q, s2_ch_q, s3_ch_q, s4_ch_q, s5_ch_q, out_ch_q;
  logic                      s1_skip_q, s2_skip_q, s3_skip_q, s4_skip_q, s5_skip_q, out_skip_q;
  logic signed [ERR_W-1:0]   s1_err_q, s2_err_q, s3_err_q, s4_err_q;
  logic signed [ERR_W-1:0]   s2_e1_q, s3_e1_q, s4_e1_q;
  logic signed [ACC_W-1:0]   s2_integ_q, s3_integ_q;
  logic signed [ACC_W-1:0]   s2_incr_q, s3_incr_q, s4_incr_q;
  logic signed [DIFF_W-1:0]  s2_dp_q, s2_dd_q;
  logic signed [PROD_W-1:0]  s3_pp_q, s3_ip_q, s3_dq_q;
  logic signed [ACC_W-1:0]   s4_integ_q;
  logic signed [SUM_W-1:0]   s4_psum_q;
  logic signed [ACC_W-1:0]   s5_res_q;
  logic signed [DRIVE_W-1:0] out_drive_q;

  assign hazard = (v1_q && !s1_skip_q && s1_ch_q == ch_in)
               || (v2_q && !s2_skip_q && s2_ch_q == ch_in)
               || (v3_q && !s3_skip_q && s3_ch_q == ch_in)
               || (v4_q && !s4_skip_q && s4_ch_q == ch_in);
  assign s_axis_tready = rdy1 && !hazard;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // stage 1: pick up state, form differences
  chan_state_t              st1;
  logic signed [DIFF_W-1:0] ex1, e1x1, e2x1, d1_1;
  logic signed [DIFF_W-1:0] dp_d, dd_d;

  assign st1  = rd_vld_q ? rd_q : '0;
  assign ex1  = DIFF_W'(s1_err_q);
  assign e1x1 = DIFF_W'(st1.e1);
  assign e2x1 = DIFF_W'(st1.e2);
  assign d1_1 = ex1 - e1x1;
  assign dp_d = (mode_q == MODE_INCREMENTAL) ? d1_1 : ex1;
  assign dd_d = (mode_q == MODE_INCREMENTAL) ? (d1_1 - e1x1 + e2x1) : d1_1;

  // stage 2: gain products
  logic signed [PROD_W-1:0] pp_d, ip_d, dq_d;

  assign pp_d = kp_q * s2_dp_q;
  assign ip_d = ki_q * s2_err_q;
  assign dq_d = kd_q * s2_dd_q;

  // stage 3: integral update and partial output sum
  logic signed [SUM_W-1:0] isum_d, psum_d;
  logic signed [ACC_W-1:0] inew_d;

  assign isum_d = (mode_q == MODE_INCREMENTAL) ? SUM_W'(s3_ip_q)
                                               : SUM_W'(s3_ip_q) + SUM_W'(s3_integ_q);
  assign inew_d = clamp_sym(isum_d, ilim_q);
  assign psum_d = SUM_W'(s3_pp_q) + SUM_W'(s3_dq_q)
                + ((mode_q == MODE_INCREMENTAL) ? SUM_W'(s3_incr_q) : SUM_W'(0));

  // stage 4: output sum, clamp, write back
  logic signed [SUM_W-1:0] rsum_d;
  logic signed [ACC_W-1:0] res_d;

  assign rsum_d = s4_psum_q + SUM_W'(s4_integ_q);
  assign res_d  = clamp_sym(rsum_d, olim_q);

  assign wr_en         = v4_q && rdy5 && !s4_skip_q;
  assign wr_idx        = IDX_W'(s4_ch_q);
  assign wr_data.e1    = s4_err_q;
  assign wr_data.e2    = s4_e1_q;
  assign wr_data.integ = s4_integ_q;
  assign wr_data.incr  = (mode_q == MODE_INCREMENTAL) ? res_d : s4_incr_q;

  // stage 5: truncate toward zero
  logic signed [DRIVE_W-1:0] drive_d;

  assign drive_d = s5_skip_q ? '0
                 : s5_res_q[ACC_W-1:FRAC_W]
                   + DRIVE_W'(s5_res_q[ACC_W-1] && (s5_res_q[FRAC_W-1:0] != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
      v5_q     <= 1'b0;
      v6_q     <= 1'b0;
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q     <= s_acc;
        rd_vld_q <= vld_q[rd_idx];
      end
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
      if (wr_en) vld_q[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_ch_q   <= ch_in;
      s1_skip_q <= skip_d;
      s1_err_q  <= err_d;
    end
    if (rdy2) begin
      s2_ch_q    <= s1_ch_q;
      s2_skip_q  <= s1_skip_q;
      s2_err_q   <= s1_err_q;
      s2_e1_q    <= st1.e1;
      s2_integ_q <= st1.integ;
      s2_incr_q  <= st1.incr;
      s2_dp_q    <= dp_d;
      s2_dd_q    <= dd_d;
    end
    if (rdy3) begin
      s3_ch_q    <= s2_ch_q;
      s3_skip_q  <= s2_skip_q;
      s3_err_q   <= s2_err_q;
      s3_e1_q    <= s2_e1_q;
      s3_integ_q <= s2_integ_q;
      s3_incr_q  <= s2_incr_q;
      s3_pp_q    <= pp_d;
      s3_ip_q    <= ip_d;
      s3_dq_q    <= dq_d;
    end
    if (rdy4) begin
      s4_ch_q    <= s3_ch_q;
      s4_skip_q  <= s3_skip_q;
      s4_err_q   <= s3_err_q;
      s4_e1_q    <= s3_e1_q;
      s4_incr_q  <= s3_incr_q;
      s4_integ_q <= inew_d;
      s4_psum_q  <= psum_d;
    end
    if (rdy5) begin
      s5_ch_q   <= s4_ch_q;
      s5_skip_q <= s4_skip_q;
      s5_res_q  <= res_d;
    end
    if (rdy6) begin
      out_ch_q    <= s5_ch_q;
      out_skip_q  <= s5_skip_q;
      out_drive_q <= drive_d;
    end
  end

  assign m_axis_tvalid = v6_q;
  assign m_axis_tdata  = out_drive_q;
  assign m_axis_tuser  = {out_skip_q, out_ch_q};

  // assertions
  logic signed [ACC_W-1:0]   ilim_fx;
  logic signed [DRIVE_W-1:0] olim_s;
  logic                      integ_ok, drive_ok;

  assign ilim_fx  = ACC_W'({ilim_q, {FRAC_W{1'b0}}});
  assign olim_s   = DRIVE_W'(olim_q);
  assign integ_ok = (s4_integ_q <= ilim_fx) && (s4_integ_q >= -ilim_fx);
  assign drive_ok = (out_drive_q <= olim_s) && (out_drive_q >= -olim_s);

  `ASSERT_RST(a_no_rw_collision, s_acc |-> !(wr_en && wr_idx == rd_idx), "read under write")
  `ASSERT_RST(a_valid_after_write, wr_en |=> vld_q[$past(wr_idx)], "entry not marked valid")
  `ASSERT_RST(a_integral_in_limit, (v4_q && !s4_skip_q) |-> integ_ok, "integral out of limit")
  `ASSERT_RST(a_drive_in_limit, m_axis_tvalid |-> drive_ok, "drive out of limit")
  `ASSERT_ANY(a_reset_clears_valid, !rst_ni |=> (vld_q == '0), "valid bits set after reset")

endmodule

// File: verif/pid_speed_controller_four_channel_test.sv
`timescale 1ns / 1ps

module pid_speed_controller_four_channel_test;
  import pidsc_pkg::*;

  localparam int ITEMS_PER_PHASE = 52;
  localparam int PHASES          = 16;
  localparam int SETTLE_CYCLES   = 10;
  localparam int HOLD_CYCLES     = 150;
  localparam int MAX_PRINTS      = 30;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic                      skipped;
    logic signed [DRIVE_W-1:0] drive;
    logic [CH_W-1:0]           ch;
  } drive_res_t;

  typedef struct packed {
    row_kind_e                 kind;
    cfg_reg_e                  idx;
    logic [CFG_DATA_W-1:0]     value;
    logic [CH_W-1:0]           ch;
    logic signed [SPD_W-1:0]   meas;
    logic signed [SPD_W-1:0]   targ;
    logic                      typed;
    logic signed [DRIVE_W-1:0] drive;
    logic                      skipped;
  } dir_row_t;

  // Rows with typed = 1 carry a result known by inspection; others use the predictor.
  localparam int DIR_ROWS = 37;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{ROW_REQ, REG_KP,    32'd0,        2'd0, 16'sd0,    16'sd0,    1'b1, 16'sd0,      1'b0},
    '{ROW_REQ, REG_KP,    32'd0,        2'd1, 16'h8000,  16'h7FFF,  1'b1, 16'sd20000,  1'b0},
    '{ROW_REQ, REG_KP,    32'd0,        2'd2, 16'h7FFF,  16'h8000,  1'b1, -16'sd20000, 1'b0},
    '{ROW_REQ, REG_KP,    32'd0,        2'd3, 16'sd100,  16'sd130,  1'b0, 16'sd0,      1'b0},
    '{ROW_REQ, REG_KP,    32'd0,        2'd3, 16'sd100,  16'sd90,   1'b0, 16'sd0,      1'b0},
    '{ROW_CFG, REG_ECEIL, 32'd100,      2'd0, 16'sd0,    16'sd0,    1'b0, 16'sd0,      1'b0},
    '{ROW_REQ, REG_KP,    32'd0,        2'd0, 16'sd0,    16'sd1000, 1'b1, 16'sd0,      1'b1},
    '{ROW_REQ, REG_KP,    32'd0,        2'd0, 16'sd0,    16'sd100,  1'b0, 16'sd0,      1'b0},
    '{ROW_CFG, REG_EDB,   32'd10,       2'd0, 16'sd0,    16'sd0,    1'b0, 16'sd0,      1'b0},
    '{ROW_REQ, REG_KP,    32'd0,        2'd1, 16'sd5,    16'sd0,    1'b1, 16'sd0,      1'b1},
    '{ROW_REQ, REG_KP,    32'd0,        2'd1, 16'sd0,    16'sd10,   1'b0, 16'sd0,      1'b0},
    '{ROW_CFG, REG_ECEIL, 32'd65535,    2'd0, 16'sd0,    16'sd0,    1'b0, 16'sd0,      1'b0},
    '{ROW_CFG, REG_EDB,   32'd65535,    2'd0, 16'sd0,    16'sd0,    1'b0, 16'sd0,      1'b0},
    '{ROW_REQ, REG_KP,    32'd0,        2'd2, 16'h8000,  16'h7FFF,  1'b0, 16'sd0,      1'b0},
    '{ROW_REQ, REG_KP,    32'd0,        2'd2, 16'sd0,    16'sd1,    1'b1, 16'sd0,      1'b1},
    '{ROW_CFG, REG_ECEIL, 32'd0,        2'd0, 16'sd0,    16'sd0,    1'b0, 16'sd0,      1'b0},
    '{ROW_CFG, REG_EDB,   32'd0,        2'd0, 16'sd0,    16'sd0,    1'b0, 16'sd0,      1'b0},
    '{ROW_CFG, REG_KD,    32'h0003_0000, 2'd0, 16'sd0,   16'sd0,    1'b0, 16'sd0,      1'b0},
    '{ROW_CFG, REG_MODE,  32'(MODE_INCREMENTAL), 2'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_REQ, REG_KP,    32'd0,        2'd0, 16'sd0,    16'sd37,   1'b0, 16'sd0,      1'b0},
    '{ROW_REQ, REG_KP,    32'd0,        2'd0, 16'sd10,   16'sd37,   1'b0, 16'sd0,      1'b0},
    '{ROW_REQ, REG_KP,    32'd0,        2'd3, -16'sd20,  16'sd0,    1'b0, 16'sd0,      1'b0},
    '{ROW_REQ, REG_KP,    32'd0,        2'd0, -16'sd5,   16'sd20,   1'b0, 16'sd0,      1'b0},
    '{ROW_CFG, REG_OLIM,  32'd0,        2'd0, 16'sd0,    16'sd0,    1'b0, 16'sd0,      1'b0},
    '{ROW_REQ, REG_KP,    32'd0,        2'd1, 16'sd0,    16'sd500,  1'b1, 16'sd0,      1'b0},
    '{ROW_CFG, REG_OLIM,  32'd32767,    2'd0, 16'sd0,    16'sd0,    1'b0, 16'sd0,      1'b0},
    '{ROW_CFG, REG_ILIM,  32'd32767,    2'd0, 16'sd0,    16'sd0,    1'b0, 16'sd0,      1'b0},
    '{ROW_CFG, REG_KP,    32'h7FFF_FFFF, 2'd0, 16'sd0,   16'sd0,    1'b0, 16'sd0,      1'b0},
    '{ROW_CFG, REG_MODE,  32'(MODE_POSITIONAL), 2'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0,   1'b0},
    '{ROW_REQ, REG_KP,    32'd0,        2'd2, 16'h8000,  16'h7FFF,  1'b1, 16'sd32767,  1'b0},
    '{ROW_CFG, REG_KP,    32'h8000_0000, 2'd0, 16'sd0,   16'sd0,    1'b0, 16'sd0,      1'b0},
    '{ROW_REQ, REG_KP,    32'd0,        2'd2, 16'h8000,  16'h7FFF,  1'b1, -16'sd32767, 1'b0},
    '{ROW_CFG, REG_ILIM,  32'd0,        2'd0, 16'sd0,    16'sd0,    1'b0, 16'sd0,      1'b0},
    '{ROW_CFG, REG_KI,    32'hFFFF_0000, 2'd0, 16'sd0,   16'sd0,    1'b0, 16'sd0,      1'b0},
    '{ROW_CFG, REG_KP,    32'h0001_0000, 2'd0, 16'sd0,   16'sd0,    1'b0, 16'sd0,      1'b0},
    '{ROW_REQ, REG_KP,    32'd0,        2'd3, 16'sd0,    16'sd25,   1'b0, 16'sd0,      1'b0},
    '{ROW_REQ, REG_KP,    32'd0,        2'd3, 16'sd3,    16'sd25,   1'b0, 16'sd0,      1'b0}
  };

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [15:0] measured_speed, [31:16] target_speed
  logic [CH_W-1:0]       s_axis_tuser  = '0;   // [1:0] channel
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [DRIVE_W-1:0]    m_axis_tdata;         // [15:0] drive_value
  logic [OUT_USER_W-1:0] m_axis_tuser;         // [1:0] channel_out, [2] skipped

  // controller settings as the block should hold them
  logic signed [GAIN_W-1:0] kp_q, ki_q, kd_q;
  logic [LIM_W-1:0]         ilim_q, olim_q;
  loop_mode_e               mode_q;
  logic [CEIL_W-1:0]        eceil_q, edb_q;

  // per-channel controller state
  logic signed [ERR_W-1:0] err_last  [CHANNELS];
  logic signed [ERR_W-1:0] err_last2 [CHANNELS];
  longint                  integ_fx  [CHANNELS];
  longint                  incr_fx   [CHANNELS];

  drive_res_t drive_q [$];

  int err_cnt    = 0;
  int n_req      = 0;
  int n_skip     = 0;
  int n_incr     = 0;
  int n_cfg      = 0;
  int n_sat      = 0;
  int send_idle  = 0;
  int recv_idle  = 0;
  bit hold_go    = 1'b0;
  bit hold_done  = 1'b0;
  int hold_cnt   = 0;

  pid_speed_controller_four_channel u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic longint sat_sym(input longint v, input longint lim);
    if (v > lim) begin
      return lim;
    end else if (v < -lim) begin
      return -lim;
    end
    return v;
  endfunction

  function automatic void apply_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] v);
    case (idx)
      REG_KP:    kp_q    = v;
      REG_KI:    ki_q    = v;
      REG_KD:    kd_q    = v;
      REG_ILIM:  ilim_q  = v[LIM_W-1:0];
      REG_OLIM:  olim_q  = v[LIM_W-1:0];
      REG_MODE:  mode_q  = loop_mode_e'(v[0]);
      REG_ECEIL: eceil_q = v[CEIL_W-1:0];
      REG_EDB:   edb_q   = v[CEIL_W-1:0];
      default: ;
    endcase
  endfunction

  // One control step; updates channel state unless the step is skipped.
  function automatic drive_res_t pid_update(input logic [CH_W-1:0] ch,
                                            input logic signed [SPD_W-1:0] meas,
                                            input logic signed [SPD_W-1:0] targ);
    drive_res_t r;
    longint e, e1, e2, mag, ilim_fx, olim_fx, ii, acc, whole;
    e       = longint'(targ) - longint'(meas);
    mag     = (e < 0) ? -e : e;
    r.ch    = ch;
    r.drive = '0;
    r.skipped = 1'b1;
    if ((eceil_q != 0 && mag > longint'(eceil_q)) || (edb_q != 0 && mag < longint'(edb_q)))
      return r;
    ilim_fx = longint'(ilim_q) <<< FRAC_W;
    olim_fx = longint'(olim_q) <<< FRAC_W;
    e1 = err_last[ch];
    e2 = err_last2[ch];
    if (mode_q == MODE_POSITIONAL) begin
      ii  = sat_sym(integ_fx[ch] + longint'(ki_q) * e, ilim_fx);
      acc = longint'(kp_q) * e + ii + longint'(kd_q) * (e - e1);
      acc = sat_sym(acc, olim_fx);
    end else begin
      ii  = sat_sym(longint'(ki_q) * e, ilim_fx);
      acc = incr_fx[ch] + longint'(kp_q) * (e - e1) + ii
          + longint'(kd_q) * (e - 2 * e1 + e2);
      acc = sat_sym(acc, olim_fx);
      incr_fx[ch] = acc;
    end
    integ_fx[ch]  = ii;
    err_last2[ch] = err_last[ch];
    err_last[ch]  = e[ERR_W-1:0];
    // fraction dropped toward zero
    whole = (acc < 0) ? -((-acc) >>> FRAC_W) : (acc >>> FRAC_W);
    r.drive   = whole[DRIVE_W-1:0];
    r.skipped = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) $display("tb: mismatch at %0t: %s", $time, msg);
  endtask

  task automatic send_req(input logic [CH_W-1:0] ch, input logic signed [SPD_W-1:0] meas,
                          input logic signed [SPD_W-1:0] targ, input bit typed,
                          input logic signed [DRIVE_W-1:0] t_drive, input bit t_skip);
    drive_res_t r;
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {targ, meas};
    s_axis_tuser  <= ch;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    r = pid_update(ch, meas, targ);
    if (typed) begin
      r.drive   = t_drive;
      r.skipped = t_skip;
    end
    n_req++;
    if (r.skipped) n_skip++;
    else if (mode_q == MODE_INCREMENTAL) n_incr++;
    if (!r.skipped && (r.drive == $signed({1'b0, olim_q}) || r.drive == -$signed({1'b0, olim_q})))
      n_sat++;
    drive_q.push_back(r);
  endtask

  // Block is idle once every request has come back and the pipe has settled.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    apply_reg(idx, v);
    n_cfg++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_reg(input cfg_reg_e idx);
    logic [CFG_DATA_W-1:0] v;
    int w;
    w = CFG_DATA_W;
    case (idx)
      REG_KP, REG_KI, REG_KD: begin
        case ($urandom_range(9))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = '0;
          3:       v = $urandom;
          default: v = 32'($urandom_range(0, 2 ** 21)) - 32'(2 ** 20);  // about +/-16.0
        endcase
      end
      REG_ILIM, REG_OLIM: begin
        w = LIM_W;
        case ($urandom_range(5))
          0:       v = '0;
          1:       v = 32'd32767;
          default: v = $urandom_range(32767);
        endcase
      end
      REG_MODE: begin
        w = 1;
        v = $urandom_range(1);
      end
      default: begin
        w = CEIL_W;
        case ($urandom_range(9))
          0, 1, 2:    v = (idx == REG_ECEIL) ? $urandom_range(100, 3000) : $urandom_range(1, 300);
          3:          v = $urandom_range(65535);
          default:    v = '0;
        endcase
      end
    endcase
    // junk above the field width must be ignored
    if (w < CFG_DATA_W && $urandom_range(1)) v = v | ($urandom << w);
    return v;
  endfunction

  // result checker
  always @(posedge clk_i) begin : result_check
    drive_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.ch      = m_axis_tuser[CH_W-1:0];
      got.skipped = m_axis_tuser[CH_W];
      got.drive   = m_axis_tdata;
      if (drive_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: ch %0d drive %0d skipped %0b",
                                  got.ch, got.drive, got.skipped));
      end else begin
        want = drive_q.pop_front();
        if (got.ch !== want.ch)
          report_mismatch($sformatf("channel %0d, want %0d", got.ch, want.ch));
        if (got.drive !== want.drive)
          report_mismatch($sformatf("ch %0d drive %0d, want %0d", want.ch, got.drive, want.drive));
        if (got.skipped !== want.skipped)
          report_mismatch($sformatf("ch %0d skipped %0b, want %0b",
                                    want.ch, got.skipped, want.skipped));
      end
    end
  end

  // receiver: random backpressure, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_go && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= hold_cnt + 1;
      if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin : stimulus
    logic signed [SPD_W-1:0] meas, targ;
    int base, delta;
    cfg_reg_e ri;

    kp_q    = KP_RST;
    ki_q    = KI_RST;
    kd_q    = KD_RST;
    ilim_q  = ILIM_RST;
    olim_q  = OLIM_RST;
    mode_q  = MODE_POSITIONAL;
    eceil_q = '0;
    edb_q   = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      err_last[c]  = '0;
      err_last2[c] = '0;
      integ_fx[c]  = 0;
      incr_fx[c]   = 0;
    end
    send_idle <= 19;
    recv_idle <= 74;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TAB[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(DIR_TAB[i].idx, DIR_TAB[i].value);
      end else begin
        send_req(DIR_TAB[i].ch, DIR_TAB[i].meas, DIR_TAB[i].targ,
                 DIR_TAB[i].typed, DIR_TAB[i].drive, DIR_TAB[i].skipped);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      if (p == 6) begin
        send_idle <= 74;
        recv_idle <= 19;
      end else if (p == 12) begin
        send_idle <= 0;
        recv_idle <= 0;
      end
      ri = ri.first();
      do begin
        write_reg(ri, pick_reg(ri));
        ri = ri.next();
      end while (ri != ri.first());
      if (p == 13) hold_go <= 1'b1;  // long output stall, input keeps coming
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(4) == 0) begin
          meas = SPD_W'($urandom);
          targ = SPD_W'($urandom);
        end else begin
          // tracking a setpoint: small errors so the integrator has work to do
          base  = $urandom_range(0, 6000) - 3000;
          delta = ($urandom_range(3) == 0) ? $urandom_range(0, 4000) - 2000
                                           : $urandom_range(0, 400) - 200;
          targ = SPD_W'(base);
          meas = SPD_W'(base - delta);
        end
        send_req(CH_W'($urandom_range(CHANNELS - 1)), meas, targ, 1'b0, '0, 1'b0);
      end
    end

    wait_idle();
    $display("tb: %0d requests over %0d setting phases, %0d register writes",
             n_req, PHASES + 1, n_cfg);
    $display("tb: %0d skipped by ceiling or deadband, %0d incremental steps, %0d at output limit",
             n_skip, n_incr, n_sat);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/pidsc_pkg.sv
rtl/pid_speed_controller_four_channel.sv
verif/pid_speed_controller_four_channel_test.sv
